// ===== src/pwows_pkg.sv =====
// ----------------------------------------------------------------------------
// pwows_pkg
// Shared types and constants for the pulse-width one-wire sender.
// ----------------------------------------------------------------------------
`default_nettype none

package pwows_pkg;

  // configuration port geometry
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int TICK_W     = 16;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_START_LOW = 2'd0;
  localparam logic [1:0] REG_LONG      = 2'd1;
  localparam logic [1:0] REG_SHORT     = 2'd2;

  // register reset values
  localparam logic [TICK_W-1:0] START_LOW_RST = 16'd2500;
  localparam logic [TICK_W-1:0] LONG_RST      = 16'd600;
  localparam logic [TICK_W-1:0] SHORT_RST     = 16'd200;

  // timing configuration seen by the sequencer
  typedef struct packed {
    logic [TICK_W-1:0] start_low_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] short_ticks;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic line_level;
    logic amp_enable;
    logic done_res;
    logic active;
  } result_t;

endpackage

`default_nettype wire

// ===== src/pwows_if.sv =====
// ----------------------------------------------------------------------------
// pwows_in_if / pwows_out_if
// Valid/ready channels for tick beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwows_in_if;
  logic       valid;
  logic       ready;
  logic       start_request;
  logic [7:0] sound_address;
  logic       busy_level;

  modport source (output valid, output start_request, output sound_address,
                  output busy_level, input ready);
  modport sink   (input valid, input start_request, input sound_address,
                  input busy_level, output ready);
endinterface

interface pwows_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic amp_enable;
  logic done_res;
  logic active;

  modport source (output valid, output line_level, output amp_enable,
                  output done_res, output active, input ready);
  modport sink   (input valid, input line_level, input amp_enable,
                  input done_res, input active, output ready);
endinterface

`default_nettype wire

// ===== src/pulse_width_one_wire_sender.sv =====
// A result beat is registered and valid the cycle after its tick is taken.
// Throughput: one tick beat per cycle while results drain; the sequencer
// state advances in a single pass; the result register frees when taken.
// Reset: synchronous active-low rst_n puts the sequencer in idle with the
// line high, clears the amplifier enable and restores default tick lengths.
// ----------------------------------------------------------------------------
// pulse_width_one_wire_sender
// Top level: register file, frame sequencer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_one_wire_sender #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  pwows_in_if.sink                              in_ch,
  pwows_out_if.source                           out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pwows_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [pwows_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [pwows_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready
);
  import pwows_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_data_r;
  logic    out_valid_r;
  logic    in_fire;

  pwows_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // accept while the result register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  pwows_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (in_fire),
    .start_request (in_ch.start_request),
    .sound_address (in_ch.sound_address),
    .busy_level    (in_ch.busy_level),
    .cfg           (cfg),
    .res           (res)
  );

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_level = out_data_r.line_level;
  assign out_ch.amp_enable = out_data_r.amp_enable;
  assign out_ch.done_res   = out_data_r.done_res;
  assign out_ch.active     = out_data_r.active;

endmodule

`default_nettype wire

// ===== src/pwows_cfg.sv =====
// ----------------------------------------------------------------------------
// pwows_cfg
// APB-style register file holding the three tick lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module pwows_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pwows_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [pwows_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [pwows_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output pwows_pkg::cfg_t                      cfg
);
  import pwows_pkg::*;

  logic [TICK_W-1:0] start_low_r;
  logic [TICK_W-1:0] long_r;
  logic [TICK_W-1:0] short_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_r <= START_LOW_RST;
      long_r      <= LONG_RST;
      short_r     <= SHORT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_LOW: start_low_r <= pwdata[TICK_W-1:0];
        REG_LONG:      long_r      <= pwdata[TICK_W-1:0];
        REG_SHORT:     short_r     <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_START_LOW: prdata = CFG_DATA_W'(start_low_r);
      REG_LONG:      prdata = CFG_DATA_W'(long_r);
      REG_SHORT:     prdata = CFG_DATA_W'(short_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.start_low_ticks = start_low_r;
  assign cfg.long_ticks      = long_r;
  assign cfg.short_ticks     = short_r;

endmodule

`default_nettype wire

// ===== src/pwows_core.sv =====
// ----------------------------------------------------------------------------
// pwows_core
// Frame sequencer: advances one tick per accepted beat and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pwows_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tick,
  input  wire logic             start_request,
  input  wire logic [7:0]       sound_address,
  input  wire logic             busy_level,
  input  wire pwows_pkg::cfg_t  cfg,
  output pwows_pkg::result_t    res
);
  import pwows_pkg::*;

  localparam int WIDE = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [WIDE-1:0] CNT_MAX = WIDE'({COUNT_WIDTH{1'b1}});

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_START_LOW = 6'b000010,
    PH_BIT_HIGH  = 6'b000100,
    PH_BIT_LOW   = 6'b001000,
    PH_WAIT_LOW  = 6'b010000,
    PH_WAIT_HIGH = 6'b100000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             bit_idx_r, bit_idx_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   line_r, line_nxt;
  logic                   en_r, en_nxt;
  logic                   done;
  logic                   cnt_zero;

  logic [TICK_W-1:0]      hi_len, lo_len, next_hi_len;
  logic [COUNT_WIDTH-1:0] load_start, load_hi, load_lo, load_next_hi;

  // period length minus one, zero treated as one, saturated to the counter
  function automatic logic [COUNT_WIDTH-1:0] period_load(input logic [TICK_W-1:0] ticks);
    logic [TICK_W-1:0] rest;
    logic [WIDE-1:0]   rest_w;
    rest   = (ticks == '0) ? '0 : ticks - 1'b1;
    rest_w = WIDE'(rest);
    if (rest_w > CNT_MAX) begin
      rest_w = CNT_MAX;
    end
    return rest_w[COUNT_WIDTH-1:0];
  endfunction

  // half-bit lengths from the current and the next lsb
  assign hi_len      = shift_r[0] ? cfg.long_ticks : cfg.short_ticks;
  assign lo_len      = shift_r[0] ? cfg.short_ticks : cfg.long_ticks;
  assign next_hi_len = shift_r[1] ? cfg.long_ticks : cfg.short_ticks;

  assign load_start   = period_load(cfg.start_low_ticks);
  assign load_hi      = period_load(hi_len);
  assign load_lo      = period_load(lo_len);
  assign load_next_hi = period_load(next_hi_len);
  assign cnt_zero     = (cnt_r == '0);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    cnt_nxt     = cnt_r;
    line_nxt    = line_r;
    en_nxt      = en_r;
    done        = 1'b0;
    unique case (phase_r)
      PH_START_LOW: begin
        if (!cnt_zero) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          line_nxt  = 1'b1;
          cnt_nxt   = load_hi;
          phase_nxt = PH_BIT_HIGH;
        end
      end
      PH_BIT_HIGH: begin
        if (!cnt_zero) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          line_nxt  = 1'b0;
          cnt_nxt   = load_lo;
          phase_nxt = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        if (!cnt_zero) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          shift_nxt = {1'b0, shift_r[7:1]};
          line_nxt  = 1'b1;
          if (bit_idx_r == 3'd7) begin
            bit_idx_nxt = '0;
            cnt_nxt     = '0;
            phase_nxt   = PH_WAIT_LOW;
          end else begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            cnt_nxt     = load_next_hi;
            phase_nxt   = PH_BIT_HIGH;
          end
        end
      end
      PH_WAIT_LOW: begin
        line_nxt = 1'b1;
        if (!busy_level) begin
          phase_nxt = PH_WAIT_HIGH;
        end
      end
      PH_WAIT_HIGH: begin
        line_nxt = 1'b1;
        if (busy_level) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        line_nxt  = 1'b1;
        if (start_request && busy_level) begin
          shift_nxt   = sound_address;
          bit_idx_nxt = '0;
          en_nxt      = 1'b1;
          line_nxt    = 1'b0;
          cnt_nxt     = load_start;
          phase_nxt   = PH_START_LOW;
        end
      end
    endcase
  end

  // state registers, advanced once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_idx_r <= '0;
      shift_r   <= '0;
      cnt_r     <= '0;
      line_r    <= 1'b1;
      en_r      <= 1'b0;
    end else if (tick) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      cnt_r     <= cnt_nxt;
      line_r    <= line_nxt;
      en_r      <= en_nxt;
    end
  end

  // result reflects the state after this tick
  assign res.line_level = line_nxt;
  assign res.amp_enable = en_nxt;
  assign res.done_res   = done;
  assign res.active     = (phase_nxt != PH_IDLE);

endmodule

`default_nettype wire
